// ----- hdl/utcldt_pkg.sv -----
// ----------------------------------------------------------------------------
// utcldt_pkg
// Shared types, constants and calendar helpers for the UTC to local date and
// time converter.
// ----------------------------------------------------------------------------
package utcldt_pkg;

    // Offset register: quarter hours biased by 48, clamped at +14:00
    localparam logic [7:0]  OFFSET_ZERO_BIASED = 8'd48;
    localparam logic [7:0]  OFFSET_MAX_BIASED  = 8'd104;

    localparam int unsigned MINUTES_PER_HOUR   = 60;
    localparam int unsigned MINUTES_PER_DAY    = 1440;
    localparam int unsigned QUARTER_MINUTES    = 15;

    // floor(w / 60) == (w * 1093) >> 16 for every w below one day
    localparam logic [10:0] RECIP_60           = 11'd1093;
    localparam int unsigned RECIP_SHIFT        = 16;

    localparam logic [11:0] YEAR_FIRST         = 12'd2000;
    localparam logic [11:0] YEAR_LAST          = 12'd2099;

    localparam logic [3:0]  MONTH_JAN          = 4'd1;
    localparam logic [3:0]  MONTH_FEB          = 4'd2;
    localparam logic [3:0]  MONTH_DEC          = 4'd12;
    localparam logic [4:0]  DAYS_IN_DEC        = 5'd31;
    localparam logic [4:0]  HOURS_HALF_DAY     = 5'd12;

    typedef struct packed {
        logic [11:0] utc_year;
        logic [3:0]  utc_month;
        logic [4:0]  utc_day;
        logic [4:0]  utc_hour;
        logic [5:0]  utc_minute;
    } in_word_t;

    typedef struct packed {
        logic [4:0]  local_hour;
        logic [5:0]  local_minute;
        logic [3:0]  hour_12;
        logic        is_pm;
        logic [11:0] local_year;
        logic [3:0]  local_month;
        logic [4:0]  local_day;
        logic        date_valid;
    } out_word_t;

    // Days in a month; zero for a month code outside January to December
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- hdl/utc_to_local_date_time.sv -----
// ----------------------------------------------------------------------------
// utc_to_local_date_time
// Converts a UTC year, month, day, hour and minute into local time using a
// programmed offset in quarter hours (biased by 48, clamped at 104). Gives
// 24-hour and 12-hour local time, and the local date moved by at most one
// day using Gregorian month lengths; date fields read zero with date_valid
// low whenever the input or the shifted date falls outside 2000 to 2099 or
// is not a real calendar date. Two register stages: a word is taken into
// the input register and its result is then registered in the output
// register; one word is accepted every cycle while the output side keeps
// taking results. Write cfg_wdata only while the pipeline is empty.
// ----------------------------------------------------------------------------
module utc_to_local_date_time
    import utcldt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,

    input  logic      cfg_we,
    input  logic [7:0] cfg_wdata,

    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_data,

    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);

    logic [7:0] utc_offset_biased_reg;

    logic       s1_valid_reg;
    in_word_t   s1_reg;
    logic       out_valid_reg;
    out_word_t  out_reg;

    logic       out_adv;
    logic       s1_load;

    // Time path
    logic [7:0]         offset_clamped;
    logic signed [7:0]  offset_qh;
    logic signed [10:0] offset_min;
    logic [10:0]        utc_mod;
    logic signed [12:0] sum;
    logic [10:0]        wrapped;
    logic [21:0]        recip_prod;
    logic [4:0]         h24;
    logic [10:0]        h24_min;
    logic [5:0]         minute;
    logic [4:0]         h12_raw;
    logic               pm;
    logic               day_fwd;
    logic               day_back;

    // Date path
    logic [11:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic        leap;
    logic [4:0]  mlen;
    logic        in_date_ok;
    logic [11:0] y_new;
    logic [3:0]  m_new;
    logic [4:0]  d_new;
    logic        date_ok;

    out_word_t   out_next;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign out_adv   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !out_adv;
    assign s1_load   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utc_offset_biased_reg <= OFFSET_ZERO_BIASED;
            s1_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                utc_offset_biased_reg <= cfg_wdata;
            end
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg <= in_data;
        end
        if (out_adv && s1_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    // ------------------------------------------------------------------
    // Minute of day and local time
    // ------------------------------------------------------------------
    always_comb
    begin
        offset_clamped = (utc_offset_biased_reg > OFFSET_MAX_BIASED) ?
                         OFFSET_MAX_BIASED : utc_offset_biased_reg;
        offset_qh      = $signed(offset_clamped - OFFSET_ZERO_BIASED);
        offset_min     = 11'(offset_qh * 11'sd15);
        utc_mod        = 11'(s1_reg.utc_hour * 11'(MINUTES_PER_HOUR))
                       + 11'(s1_reg.utc_minute);
        sum            = $signed({2'b00, utc_mod}) + 13'(offset_min);

        day_back = sum[12];
        day_fwd  = !sum[12] && (sum >= 13'sd1440);

        // Sum spans just under two days above zero and half a day below
        if (day_back)
        begin
            wrapped = 11'(sum + 13'sd1440);
        end
        else if (sum >= 13'sd2880)
        begin
            wrapped = 11'(sum - 13'sd2880);
        end
        else if (day_fwd)
        begin
            wrapped = 11'(sum - 13'sd1440);
        end
        else
        begin
            wrapped = 11'(sum);
        end

        recip_prod = {11'd0, wrapped} * {11'd0, RECIP_60};
        h24        = recip_prod[RECIP_SHIFT +: 5];
        h24_min    = 11'(h24 * 11'(MINUTES_PER_HOUR));
        minute     = 6'(wrapped - h24_min);
        pm         = (h24 >= HOURS_HALF_DAY);
        h12_raw    = pm ? (h24 - HOURS_HALF_DAY) : h24;
    end

    // ------------------------------------------------------------------
    // Local date, moved by at most one day
    // ------------------------------------------------------------------
    always_comb
    begin
        y    = s1_reg.utc_year;
        m    = s1_reg.utc_month;
        d    = s1_reg.utc_day;
        // Century years other than 2000 fall outside the valid range anyway
        leap = (y[1:0] == 2'b00);
        mlen = month_len(m, leap);

        in_date_ok = (y >= YEAR_FIRST) && (y <= YEAR_LAST) && (mlen != 5'd0)
                   && (d != 5'd0) && (d <= mlen);

        y_new = y;
        m_new = m;
        d_new = d;
        if (day_fwd)
        begin
            if (d < mlen)
            begin
                d_new = d + 5'd1;
            end
            else
            begin
                d_new = 5'd1;
                if (m == MONTH_DEC)
                begin
                    m_new = MONTH_JAN;
                    y_new = y + 12'd1;
                end
                else
                begin
                    m_new = m + 4'd1;
                end
            end
        end
        else if (day_back)
        begin
            if (d > 5'd1)
            begin
                d_new = d - 5'd1;
            end
            else if (m > MONTH_JAN)
            begin
                m_new = m - 4'd1;
                d_new = month_len(m - 4'd1, leap);
            end
            else
            begin
                m_new = MONTH_DEC;
                y_new = y - 12'd1;
                d_new = DAYS_IN_DEC;
            end
        end

        // A valid date stays a real date; only the year can leave the range
        date_ok = in_date_ok && (y_new >= YEAR_FIRST) && (y_new <= YEAR_LAST);
    end

    always_comb
    begin
        out_next.local_hour   = h24;
        out_next.local_minute = minute;
        out_next.hour_12      = (h12_raw == 5'd0) ? 4'd12 : h12_raw[3:0];
        out_next.is_pm        = pm;
        out_next.local_year   = date_ok ? y_new : 12'd0;
        out_next.local_month  = date_ok ? m_new : 4'd0;
        out_next.local_day    = date_ok ? d_new : 5'd0;
        out_next.date_valid   = date_ok;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty input register");

    a_word_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_adv) |=> out_valid_reg)
        else $error("word in the input register did not reach the output");

    a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.local_hour < 5'd24) && (out_reg.local_minute < 6'd60))
        else $error("local time outside one day");

    a_twelve_hour: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.hour_12 >= 4'd1) && (out_reg.hour_12 <= 4'd12)
                          && (out_reg.is_pm == (out_reg.local_hour >= 5'd12)))
        else $error("12-hour form disagrees with local hour");

    a_invalid_date_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.date_valid) |->
            (out_reg.local_year == 12'd0) && (out_reg.local_month == 4'd0)
            && (out_reg.local_day == 5'd0))
        else $error("invalid date carries non-zero date fields");

endmodule
